// ===== design/trti_pkg.sv =====
// Package for the timed ramp/triangle increment core.
// Holds register indexes, widths, the tick rate constant and the sequencer state type.
// No dependencies.
package trti_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int VAL_W       = 16;
	localparam int GAP_W       = 24;
	localparam int TEMP_W      = 12;
	localparam int CNT_W       = 4;

	localparam logic [7:0] CYCLE_MINUTES = 8'd2;
	localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = 12'd4095;

	localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_TYPE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DURATION     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PEAK_TIME    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_INH_EN  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LIMIT   = 3'd7;

	localparam logic [1:0] PROF_CONSTANT = 2'd0;
	localparam logic [1:0] PROF_RAMP     = 2'd1;
	localparam logic [1:0] PROF_TRIANGLE = 2'd2;
	localparam logic [1:0] PROF_UNUSED   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_WRITE
	} state_t;

endpackage

// ===== design/timed_ramp_triangle_increment_core.sv =====
// Top level of the timed ramp/triangle increment core.
// Tick decision logic, bit-serial divider and multiplier, result register.
// Depends on trti_pkg.
//
//  channel   handshake              payload
//  --------  ---------------------  -----------------------------------------
//  cfg       cfg_write              cfg_index, cfg_data
//  in        in_valid / in_stall    start_request, event_gap, temperature
//  out       out_valid / out_stall  increment, active, elapsed, running
//
// A request that needs a ramp or triangle value passes from accept through the
// radix-2 restoring divider and the shift-add multiplier to the write step, which
// loads the result register; other requests go from accept straight to the write step.
// The next request can be taken in the cycle after the result loads.
// Reset clears all control state; temp_limit resets to 4095.
// A new request is taken while a result waits on out_stall; the sequencer
// holds in its write step until the result register is free.
module timed_ramp_triangle_increment_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [trti_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [trti_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                start_request,
	input  logic [trti_pkg::GAP_W-1:0]          event_gap,
	input  logic [trti_pkg::TEMP_W-1:0]         temperature,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [trti_pkg::VAL_W-1:0]   increment,
	output logic                                active,
	output logic [trti_pkg::VAL_W-1:0]          elapsed,
	output logic                                running
);

	localparam int W = trti_pkg::VAL_W;

	logic                           enable_q;
	logic signed [W-1:0]            amplitude_q;
	logic [1:0]                     profile_type_q;
	logic [W-1:0]                   duration_q;
	logic [W-1:0]                   peak_time_q;
	logic [trti_pkg::GAP_W-1:0]     min_gap_q;
	logic                           temp_inh_en_q;
	logic [trti_pkg::TEMP_W-1:0]    temp_limit_q;

	logic                           armed_q;
	logic                           counting_q;
	logic [W-1:0]                   elapsed_q;
	logic [W-1:0]                   incr_q;

	trti_pkg::state_t               state_q, state_n;
	logic [trti_pkg::CNT_W-1:0]     cnt_q;
	logic [W-1:0]                   div_q;
	logic [W-1:0]                   dvd_q;
	logic [W-1:0]                   rem_q;
	logic [W-1:0]                   mult_q;
	logic [W-1:0]                   mcand_q;
	logic [W-1:0]                   acc_q;
	logic                           neg_q;
	logic                           sub_q;

	logic                           out_valid_q;
	logic [W-1:0]                   out_incr_q;
	logic                           out_active_q;
	logic [W-1:0]                   out_elapsed_q;
	logic                           out_running_q;

	logic                           accept;
	logic                           out_free;
	logic                           armed_n;
	logic                           counting_n;
	logic [W-1:0]                   elapsed_n;
	logic [W-1:0]                   incr_n;
	logic                           calc;
	logic [W-1:0]                   calc_div;
	logic [W-1:0]                   calc_t;
	logic                           calc_sub;
	logic [W-1:0]                   el0;
	logic [W-1:0]                   inc0;
	logic [W:0]                     el_sum;
	logic [W:0]                     trial;
	logic [W:0]                     diff;
	logic                           cnt_last;

	assign in_stall  = (state_q != trti_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_last  = (cnt_q == {trti_pkg::CNT_W{1'b1}});
	assign trial     = {rem_q, dvd_q[W-1]};
	assign diff      = trial - {1'b0, div_q};

	assign out_valid = out_valid_q;
	assign increment = out_incr_q;
	assign active    = out_active_q;
	assign elapsed   = out_elapsed_q;
	assign running   = out_running_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			amplitude_q    <= '0;
			profile_type_q <= trti_pkg::PROF_CONSTANT;
			duration_q     <= '0;
			peak_time_q    <= '0;
			min_gap_q      <= '0;
			temp_inh_en_q  <= 1'b0;
			temp_limit_q   <= trti_pkg::TEMP_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				trti_pkg::REG_ENABLE:       enable_q       <= cfg_data[0];
				trti_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_data[W-1:0];
				trti_pkg::REG_PROFILE_TYPE: profile_type_q <= cfg_data[1:0];
				trti_pkg::REG_DURATION:     duration_q     <= cfg_data[W-1:0];
				trti_pkg::REG_PEAK_TIME:    peak_time_q    <= cfg_data[W-1:0];
				trti_pkg::REG_MIN_GAP:      min_gap_q      <= cfg_data;
				trti_pkg::REG_TEMP_INH_EN:  temp_inh_en_q  <= cfg_data[0];
				trti_pkg::REG_TEMP_LIMIT:   temp_limit_q   <= cfg_data[trti_pkg::TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// Tick decision for the accepted request
	always_comb begin
		el0        = counting_q ? elapsed_q : '0;
		inc0       = counting_q ? incr_q : amplitude_q;
		el_sum     = {1'b0, el0} + {{(W-7){1'b0}}, trti_pkg::CYCLE_MINUTES};
		armed_n    = armed_q | start_request;
		counting_n = counting_q;
		elapsed_n  = elapsed_q;
		incr_n     = incr_q;
		calc       = 1'b0;
		calc_div   = duration_q;
		calc_t     = el0;
		calc_sub   = 1'b1;
		if (enable_q) begin
			if (armed_n && (event_gap > min_gap_q)) begin
				if (el0 < duration_q) begin
					counting_n = 1'b1;
					elapsed_n  = el_sum[W] ? {W{1'b1}} : el_sum[W-1:0];
					incr_n     = inc0;
					case (profile_type_q)
						trti_pkg::PROF_RAMP: begin
							calc = 1'b1;
						end
						trti_pkg::PROF_TRIANGLE: begin
							if (el0 <= peak_time_q) begin
								if (peak_time_q == '0) begin
									incr_n = amplitude_q;
								end else begin
									calc     = 1'b1;
									calc_div = peak_time_q;
									calc_sub = 1'b0;
								end
							end else begin
								calc     = 1'b1;
								calc_div = duration_q - peak_time_q;
								calc_t   = el0 - peak_time_q;
							end
						end
						default: ;
					endcase
				end else begin
					armed_n    = 1'b0;
					counting_n = 1'b0;
					elapsed_n  = '0;
					incr_n     = '0;
				end
			end
		end else if (armed_n) begin
			armed_n    = 1'b0;
			counting_n = 1'b0;
			elapsed_n  = '0;
			incr_n     = '0;
		end
		if (temp_inh_en_q && (temperature > temp_limit_q)) begin
			armed_n    = 1'b0;
			counting_n = 1'b0;
			elapsed_n  = '0;
			incr_n     = '0;
			calc       = 1'b0;
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trti_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			trti_pkg::ST_IDLE: begin
				if (accept) begin
					state_n = calc ? trti_pkg::ST_DIV : trti_pkg::ST_WRITE;
				end
			end
			trti_pkg::ST_DIV: begin
				if (cnt_last) begin
					state_n = trti_pkg::ST_MUL;
				end
			end
			trti_pkg::ST_MUL: begin
				if (cnt_last) begin
					state_n = trti_pkg::ST_WRITE;
				end
			end
			trti_pkg::ST_WRITE: begin
				if (out_free) begin
					state_n = trti_pkg::ST_IDLE;
				end
			end
			default: state_n = trti_pkg::ST_IDLE;
		endcase
	end

	// Profile state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b0;
			counting_q <= 1'b0;
			elapsed_q  <= '0;
			incr_q     <= '0;
			cnt_q      <= '0;
		end else begin
			if (accept) begin
				armed_q    <= armed_n;
				counting_q <= counting_n;
				elapsed_q  <= elapsed_n;
				incr_q     <= incr_n;
				cnt_q      <= '0;
			end else if (state_q == trti_pkg::ST_DIV || state_q == trti_pkg::ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == trti_pkg::ST_MUL && cnt_last) begin
				incr_q <= sub_q ? (amplitude_q - (acc_q + (mult_q[0] ? mcand_q : '0)))
				                : (acc_q + (mult_q[0] ? mcand_q : '0));
			end
		end
	end

	// Bit-serial divide of |amplitude| by the span, then shift-add multiply by time
	always_ff @(posedge clk) begin
		case (state_q)
			trti_pkg::ST_IDLE: begin
				if (accept) begin
					div_q  <= calc_div;
					dvd_q  <= amplitude_q[W-1] ? (-amplitude_q) : amplitude_q;
					rem_q  <= '0;
					mult_q <= calc_t;
					neg_q  <= amplitude_q[W-1];
					sub_q  <= calc_sub;
					acc_q  <= '0;
				end
			end
			trti_pkg::ST_DIV: begin
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
				end else begin
					rem_q <= trial[W-1:0];
				end
				dvd_q <= {dvd_q[W-2:0], !diff[W]};
				if (cnt_last) begin
					mcand_q <= neg_q ? (-{dvd_q[W-2:0], !diff[W]}) : {dvd_q[W-2:0], !diff[W]};
				end
			end
			trti_pkg::ST_MUL: begin
				if (mult_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[W-2:0], 1'b0};
				mult_q  <= {1'b0, mult_q[W-1:1]};
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == trti_pkg::ST_WRITE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == trti_pkg::ST_WRITE && out_free) begin
			out_incr_q    <= incr_q;
			out_active_q  <= armed_q;
			out_elapsed_q <= counting_q ? elapsed_q : '0;
			out_running_q <= counting_q;
		end
	end

endmodule
